// ----- sv/wrps_pkg.sv -----
// wrps_pkg: widths, register indexes, lookup tables and fixed-point helpers
// for the water reflection texel shader. No dependencies.
package wrps_pkg;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 48;
    localparam int FRAC_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_TEX_WIDTH  = 320;
    localparam int DEF_TEX_HEIGHT = 240;

    localparam logic [CFG_IDX_W-1:0] REG_ZENITH_COLOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLINT_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON_ALPHA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUN_COLUMN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUN_FACING    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHINE_RATE    = 3'd7;

    localparam logic [15:0] RST_BASE_ALPHA    = 16'd11796;
    localparam logic [15:0] RST_HORIZON_ALPHA = 16'd24904;
    localparam logic [15:0] RST_SUN_COLUMN    = 16'd32768;
    localparam logic [15:0] RST_SUN_FACING    = 16'd32768;
    localparam logic [15:0] RST_SHINE_RATE    = 16'd0;

    localparam logic [16:0] RIPPLE_BASE  = 17'd51118;
    localparam logic [16:0] RIPPLE_AMP   = 17'd14418;
    localparam logic [16:0] GLINT_ALPHA  = 17'd27525;
    localparam logic [17:0] ALPHA_MIN    = 18'd7864;
    localparam logic [17:0] ALPHA_MAX    = 18'd47186;
    localparam logic [16:0] COLOR_MAX    = 17'd65280;
    localparam logic [36:0] PHASE_U_MUL  = 37'd500658;
    localparam logic [36:0] PHASE_V_MUL  = 37'd333772;

    // Gaussian, sigma 0.14, sampled every 1/32
    function automatic logic [16:0] gauss_lut(input logic [5:0] i);
        logic [16:0] r;
        case (i)
            6'd0:  r = 17'd65536;
            6'd1:  r = 17'd63924;
            6'd2:  r = 17'd59320;
            6'd3:  r = 17'd52373;
            6'd4:  r = 17'd43992;
            6'd5:  r = 17'd35156;
            6'd6:  r = 17'd26729;
            6'd7:  r = 17'd19335;
            6'd8:  r = 17'd13306;
            6'd9:  r = 17'd8712;
            6'd10: r = 17'd5427;
            6'd11: r = 17'd3216;
            6'd12: r = 17'd1813;
            6'd13: r = 17'd973;
            6'd14: r = 17'd496;
            6'd15: r = 17'd241;
            6'd16: r = 17'd111;
            6'd17: r = 17'd49;
            6'd18: r = 17'd20;
            6'd19: r = 17'd8;
            6'd20: r = 17'd3;
            6'd21: r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // quarter-wave sine, 16 steps
    function automatic logic [16:0] sine_lut(input logic [4:0] k);
        logic [16:0] r;
        case (k)
            5'd0:  r = 17'd0;
            5'd1:  r = 17'd6424;
            5'd2:  r = 17'd12785;
            5'd3:  r = 17'd19024;
            5'd4:  r = 17'd25080;
            5'd5:  r = 17'd30893;
            5'd6:  r = 17'd36410;
            5'd7:  r = 17'd41576;
            5'd8:  r = 17'd46341;
            5'd9:  r = 17'd50660;
            5'd10: r = 17'd54491;
            5'd11: r = 17'd57798;
            5'd12: r = 17'd60547;
            5'd13: r = 17'd62714;
            5'd14: r = 17'd64277;
            5'd15: r = 17'd65220;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    // (x*y + half) >> 16
    function automatic logic [16:0] mul16(input logic [16:0] x, input logic [16:0] y);
        logic [33:0] p;
        p = 34'(x) * 34'(y) + 34'd32768;
        return p[32:16];
    endfunction

    // (a*(1-t) + b*t + half) >> 16
    function automatic logic [16:0] blend16(input logic [16:0] a, input logic [16:0] b,
                                            input logic [16:0] t);
        logic [16:0] tn;
        logic [34:0] s;
        tn = 17'h10000 - t;
        s = 35'(a) * 35'(tn) + 35'(b) * 35'(t) + 35'd32768;
        return s[32:16];
    endfunction

endpackage

// ----- sv/wrps_px_in_if.sv -----
// wrps_px_in_if: texel coordinate channel (valid/ready).
// Depends on wrps_pkg.
interface wrps_px_in_if;
    import wrps_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    modport source (output valid, column, row, input ready);
    modport sink   (input valid, column, row, output ready);
endinterface

// ----- sv/wrps_px_out_if.sv -----
// wrps_px_out_if: RGBA8 texel result channel (valid/ready).
// Depends on wrps_pkg.
interface wrps_px_out_if;
    import wrps_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ----- sv/wrps_cfg_if.sv -----
// wrps_cfg_if: register write channel, index plus data (valid/ready).
// Depends on wrps_pkg.
interface wrps_cfg_if;
    import wrps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/water_reflection_pixel_shader_core.sv -----
// water_reflection_pixel_shader_core: 10-stage texel pipeline and config registers.
// Depends on wrps_pkg, wrps_px_in_if, wrps_px_out_if, wrps_cfg_if.

// One RGBA8 reflection texel per coordinate transaction, one transaction per clock
// sustained while results are taken. The whole pipeline advances together; it holds
// when the result register is full and not taken, so i_px.ready follows o_px.ready
// combinationally. Coordinate normalization uses a reciprocal multiply and one
// correction step, so TEX_WIDTH/TEX_HEIGHT may be any value in 2..4096. Config
// writes are always accepted and take effect at once; write them only while no
// texel is in flight.
module water_reflection_pixel_shader_core #(
    parameter int TEX_WIDTH  = wrps_pkg::DEF_TEX_WIDTH,
    parameter int TEX_HEIGHT = wrps_pkg::DEF_TEX_HEIGHT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wrps_cfg_if.sink      i_cfg,
    wrps_px_in_if.sink    i_px,
    wrps_px_out_if.source o_px
);
    import wrps_pkg::*;

    localparam logic [11:0] TOP_U  = 12'(TEX_WIDTH - 1);
    localparam logic [11:0] TOP_V  = 12'(TEX_HEIGHT - 1);
    localparam logic [27:0] HALF_U = 28'((TEX_WIDTH - 1) / 2);
    localparam logic [27:0] HALF_V = 28'((TEX_HEIGHT - 1) / 2);
    // one extra bit so a size of 2 (divisor 1) keeps its full reciprocal
    localparam logic [28:0] RCP_U  = 29'((64'd1 << 28) / (TEX_WIDTH - 1));
    localparam logic [28:0] RCP_V  = 29'((64'd1 << 28) / (TEX_HEIGHT - 1));
    localparam int NSTG = 10;

    // config registers
    logic [47:0] r_zenith, r_horizon, r_glint;
    logic [15:0] r_base_a, r_hor_a, r_sun_col, r_sun_face, r_shine;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zenith   <= '0;
            r_horizon  <= '0;
            r_glint    <= '0;
            r_base_a   <= RST_BASE_ALPHA;
            r_hor_a    <= RST_HORIZON_ALPHA;
            r_sun_col  <= RST_SUN_COLUMN;
            r_sun_face <= RST_SUN_FACING;
            r_shine    <= RST_SHINE_RATE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ZENITH_COLOR:  r_zenith   <= i_cfg.data;
                REG_HORIZON_COLOR: r_horizon  <= i_cfg.data;
                REG_GLINT_COLOR:   r_glint    <= i_cfg.data;
                REG_BASE_ALPHA:    r_base_a   <= i_cfg.data[15:0];
                REG_HORIZON_ALPHA: r_hor_a    <= i_cfg.data[15:0];
                REG_SUN_COLUMN:    r_sun_col  <= i_cfg.data[15:0];
                REG_SUN_FACING:    r_sun_face <= i_cfg.data[15:0];
                REG_SHINE_RATE:    r_shine    <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic            en;

    assign en         = !r_vld[NSTG-1] || o_px.ready;
    assign i_px.ready = en;
    assign o_px.valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_px.valid};
        end
    end

    // stage registers
    logic [27:0] r1_nu, r1_nv, r2_nu, r2_nv;
    logic [16:0] r2_qu, r2_qv;
    logic [16:0] r3_u, r3_v;
    logic [16:0] r4_du, r4_vv;
    logic [15:0] r4_turn;
    logic [16:0] r4_sky [3], r5_sky [3], r6_sky [3], r7_sky [3], r8_sky [3];
    logic [16:0] r5_gauss, r5_sin, r5_fres;
    logic        r5_neg;
    logic [16:0] r6_bloom, r6_ripple, r6_fres;
    logic [16:0] r7_bs, r7_ripple, r7_fres;
    logic [16:0] r8_g, r8_fres;
    logic [16:0] r9_c [3];
    logic [17:0] r9_a;

    // stage 1 comb
    logic [11:0] ku, kv;
    // stage 2 comb
    logic [56:0] pu, pv;
    // stage 3 comb
    logic [28:0] remu, remv;
    // stage 4 comb
    logic [16:0] n_du;
    logic [36:0] phase;
    // stage 5 comb
    logic [5:0]  gi;
    logic [10:0] gf;
    logic [29:0] gsum;
    logic [1:0]  quad;
    logic [14:0] sp;
    logic [4:0]  si;
    logic [9:0]  sf;
    logic [27:0] ssum;
    // stage 6 comb
    logic [16:0] rip_amp;
    // stage 9 comb
    logic [17:0] a_sum;
    // stage 10 comb
    logic [16:0] c_cl [3];
    logic [16:0] c_rnd [3];
    logic [17:0] a_cl;
    logic [25:0] a_scl;

    always_comb begin
        ku = (i_px.column > TOP_U) ? TOP_U : i_px.column;
        kv = (i_px.row > TOP_V) ? TOP_V : i_px.row;
        pu = 57'(r1_nu) * 57'(RCP_U);
        pv = 57'(r1_nv) * 57'(RCP_V);
        // quotient estimate is short by at most one
        remu = 29'(r2_nu) - 29'(r2_qu) * 29'(TOP_U);
        remv = 29'(r2_nv) - 29'(r2_qv) * 29'(TOP_V);
        n_du = (r3_u > 17'(r_sun_col)) ? r3_u - 17'(r_sun_col) : 17'(r_sun_col) - r3_u;
        phase = 37'(r3_u) * PHASE_U_MUL + 37'(r3_v) * PHASE_V_MUL + 37'd32768;
        // gaussian interpolation, 11 fraction bits
        gi = r4_du[16:11];
        gf = r4_du[10:0];
        gsum = 30'(gauss_lut(gi)) * 30'(12'd2048 - 12'(gf))
             + 30'(gauss_lut(gi + 6'd1)) * 30'(gf) + 30'd1024;
        // quarter-wave mirror
        quad = r4_turn[15:14];
        sp   = quad[0] ? 15'd16384 - 15'(r4_turn[13:0]) : 15'(r4_turn[13:0]);
        si   = sp[14:10];
        sf   = sp[9:0];
        ssum = 28'(sine_lut(si)) * 28'(11'd1024 - 11'(sf))
             + 28'(sine_lut(si + 5'd1)) * 28'(sf) + 28'd512;
        rip_amp = mul16(RIPPLE_AMP, r5_sin);
        a_sum = 18'(r8_fres) + 18'(mul16(r8_g, GLINT_ALPHA));
        for (int k = 0; k < 3; k++) begin
            c_cl[k]  = (r9_c[k] > COLOR_MAX) ? COLOR_MAX : r9_c[k];
            c_rnd[k] = c_cl[k] + 17'd128;
        end
        a_cl  = (r9_a < ALPHA_MIN) ? ALPHA_MIN : ((r9_a > ALPHA_MAX) ? ALPHA_MAX : r9_a);
        a_scl = 26'(a_cl) * 26'd255 + 26'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // 1: clamp and scale coordinates
            r1_nu <= {ku, 16'd0} + HALF_U;
            r1_nv <= {kv, 16'd0} + HALF_V;
            // 2: reciprocal estimate
            r2_nu <= r1_nu;
            r2_nv <= r1_nv;
            r2_qu <= pu[44:28];
            r2_qv <= pv[44:28];
            // 3: correct quotient
            r3_u <= (remu >= 29'(TOP_U)) ? r2_qu + 17'd1 : r2_qu;
            r3_v <= (remv >= 29'(TOP_V)) ? r2_qv + 17'd1 : r2_qv;
            // 4: distance to sun, v squared, ripple phase, sky color
            r4_du   <= n_du;
            r4_vv   <= mul16(r3_v, r3_v);
            r4_turn <= phase[31:16];
            for (int k = 0; k < 3; k++) begin
                r4_sky[k] <= blend16(17'(r_zenith[16*k +: 16]), 17'(r_horizon[16*k +: 16]),
                                     r3_v);
            end
            // 5: table lookups, fresnel opacity
            r5_gauss <= (gi >= 6'd32) ? 17'd0 : gsum[27:11];
            r5_sin   <= ssum[26:10];
            r5_neg   <= quad[1];
            r5_fres  <= blend16(17'(r_base_a), 17'(r_hor_a), r4_vv);
            r5_sky   <= r4_sky;
            // 6: bloom and ripple
            r6_bloom  <= mul16(r5_gauss, 17'(r_sun_face));
            r6_ripple <= r5_neg ? RIPPLE_BASE - rip_amp : RIPPLE_BASE + rip_amp;
            r6_fres   <= r5_fres;
            r6_sky    <= r5_sky;
            // 7
            r7_bs     <= mul16(r6_bloom, 17'(r_shine));
            r7_ripple <= r6_ripple;
            r7_fres   <= r6_fres;
            r7_sky    <= r6_sky;
            // 8: glint strength
            r8_g    <= mul16(r7_bs, r7_ripple);
            r8_fres <= r7_fres;
            r8_sky  <= r7_sky;
            // 9: glint blend, opacity sum
            for (int k = 0; k < 3; k++) begin
                r9_c[k] <= blend16(r8_sky[k], 17'(r_glint[16*k +: 16]), r8_g);
            end
            r9_a <= a_sum;
            // 10: clamp and round to bytes
            o_px.red   <= c_rnd[0][15:8];
            o_px.green <= c_rnd[1][15:8];
            o_px.blue  <= c_rnd[2][15:8];
            o_px.alpha <= a_scl[23:16];
        end
    end

endmodule
